FILE: hdl/c8x_pkg.sv
// c8x_pkg: shared constants and codes for the chip-8 instruction executor
// no dependencies; imported by the top level
`timescale 1ns / 1ps

package c8x_pkg;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned MEM_AW      = 12;
  localparam int unsigned SCREEN_W    = 64;
  localparam int unsigned SCREEN_H    = 32;
  localparam int unsigned ROW_AW      = 5;
  localparam int unsigned STACK_DEPTH = 16;

  localparam logic [MEM_AW-1:0] PC_START = 12'h200;
  localparam logic [15:0]       INS_CLS  = 16'h00E0;
  localparam logic [15:0]       INS_RET  = 16'h00EE;

  typedef enum logic [2:0] {
    OP_STEP   = 3'd0,
    OP_WRMEM  = 3'd1,
    OP_TICK   = 3'd2,
    OP_RDMEM  = 3'd3,
    OP_RDROW  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_UNKNOWN = 2'd1,
    FLT_OVER    = 2'd2,
    FLT_UNDER   = 2'd3
  } fault_e;

  // top nibble classes
  localparam logic [3:0] CL_SYS  = 4'h0;
  localparam logic [3:0] CL_JP   = 4'h1;
  localparam logic [3:0] CL_CALL = 4'h2;
  localparam logic [3:0] CL_SEB  = 4'h3;
  localparam logic [3:0] CL_SNEB = 4'h4;
  localparam logic [3:0] CL_SER  = 4'h5;
  localparam logic [3:0] CL_LDB  = 4'h6;
  localparam logic [3:0] CL_ADDB = 4'h7;
  localparam logic [3:0] CL_ALU  = 4'h8;
  localparam logic [3:0] CL_SNER = 4'h9;
  localparam logic [3:0] CL_LDI  = 4'hA;
  localparam logic [3:0] CL_JPV0 = 4'hB;
  localparam logic [3:0] CL_RND  = 4'hC;
  localparam logic [3:0] CL_DRW  = 4'hD;
  localparam logic [3:0] CL_KEY  = 4'hE;

  // alu sub codes
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // key and misc sub codes
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] F_GDLY   = 8'h07;
  localparam logic [7:0] F_WKEY   = 8'h0A;
  localparam logic [7:0] F_SDLY   = 8'h15;
  localparam logic [7:0] F_SSND   = 8'h18;
  localparam logic [7:0] F_ADDI   = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STO    = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

endpackage

FILE: hdl/chip8_instruction_executor.sv
// chip8_instruction_executor: sequencer around main memory, register file,
// frame buffer and return stack memories; depends on c8x_pkg
// a sprite draws one row per pass through ST_DR0 and ST_DR1, and FX55/FX65
// move one register per pass through their read and write states; one request
// in flight, as a request is taken only in ST_IDLE
// reset: asynchronous; afterwards a clearing pass zeroes main memory and
// the registers while no request is taken; frame rows clear through valid bits
`timescale 1ns / 1ps

module chip8_instruction_executor
  import c8x_pkg::*;
#(
  parameter int unsigned StackDepth = STACK_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          op_i,
  input  logic [MEM_AW-1:0]   addr_i,
  input  logic [7:0]          wdata_i,
  input  logic [15:0]         key_state_i,
  input  logic [7:0]          random_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MEM_AW-1:0]   pc_now_o,
  output logic [SCREEN_W-1:0] read_data_o,
  output logic                waiting_o,
  output logic                sound_on_o,
  output logic [1:0]          fault_o
);

  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned StW = $clog2(StackDepth);

  typedef enum logic [19:0] {
    ST_CLEAR  = 20'h00001,
    ST_IDLE   = 20'h00002,
    ST_DISP   = 20'h00004,
    ST_RDM    = 20'h00008,
    ST_RDF    = 20'h00010,
    ST_FETCH1 = 20'h00020,
    ST_FETCH2 = 20'h00040,
    ST_RDY    = 20'h00080,
    ST_EXEC   = 20'h00100,
    ST_RET    = 20'h00200,
    ST_BCD1   = 20'h00400,
    ST_BCD2   = 20'h00800,
    ST_SRD    = 20'h01000,
    ST_SWR    = 20'h02000,
    ST_LRD    = 20'h04000,
    ST_LWR    = 20'h08000,
    ST_DR0    = 20'h10000,
    ST_DR1    = 20'h20000,
    ST_WRF    = 20'h40000,
    ST_DONE   = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // request fields
  logic [2:0]        op_q;
  logic [MEM_AW-1:0] addr_q;
  logic [7:0]        wdata_q;
  logic [15:0]       keys_q;
  logic [7:0]        rnd_q;

  // architectural state
  logic [MEM_AW-1:0] pc_q, pc_d;
  logic [MEM_AW-1:0] i_q, i_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic [7:0]        dly_q, dly_d;
  logic [7:0]        snd_q, snd_d;
  logic              kwait_q, kwait_d;
  logic [3:0]        kdest_q, kdest_d;
  logic [SCREEN_H-1:0] fbv_q, fbv_d;

  // working registers
  logic [15:0]         ins_q, ins_d;
  logic [7:0]          vx_q, vx_d;
  logic [7:0]          vy_q, vy_d;
  logic [MEM_AW-1:0]   cnt_q, cnt_d;
  logic                hit_q, hit_d;
  logic [7:0]          flag_q, flag_d;
  logic [7:0]          rem_q, rem_d;
  logic [7:0]          ones_q, ones_d;
  logic [SCREEN_W-1:0] rd_q, rd_d;
  logic [1:0]          flt_q, flt_d;

  // output register
  logic                out_valid_q;
  logic [MEM_AW-1:0]   pc_now_q;
  logic [SCREEN_W-1:0] read_data_q;
  logic                waiting_q, sound_on_q;
  logic [1:0]          fault_q;
  logic                out_load;

  // memory ports
  logic                mem_we;
  logic [MEM_AW-1:0]   mem_addr;
  logic [7:0]          mem_wd, mem_rdata;
  logic                reg_we;
  logic [3:0]          reg_addr;
  logic [7:0]          reg_wd, reg_rdata;
  logic                fb_we;
  logic [ROW_AW-1:0]   fb_addr;
  logic [SCREEN_W-1:0] fb_wd, fb_rdata;
  logic                stk_we;
  logic [StW-1:0]      stk_addr;
  logic [MEM_AW-1:0]   stk_wd, stk_rdata;

  logic [7:0]  main_mem [MEM_BYTES];
  logic [7:0]  reg_mem  [16];
  logic [SCREEN_W-1:0] fb_mem [SCREEN_H];
  logic [MEM_AW-1:0]   stk_mem [StackDepth];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      main_mem[mem_addr] <= mem_wd;
    end
    mem_rdata <= main_mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      reg_mem[reg_addr] <= reg_wd;
    end
    reg_rdata <= reg_mem[reg_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      fb_mem[fb_addr] <= fb_wd;
    end
    fb_rdata <= fb_mem[fb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_addr] <= stk_wd;
    end
    stk_rdata <= stk_mem[stk_addr];
  end

  // instruction fields
  logic [3:0]        cls, xf, yf, nf;
  logic [7:0]        nn;
  logic [MEM_AW-1:0] nnn;
  assign cls = ins_q[15:12];
  assign xf  = ins_q[11:8];
  assign yf  = ins_q[7:4];
  assign nf  = ins_q[3:0];
  assign nn  = ins_q[7:0];
  assign nnn = ins_q[11:0];

  // lowest held key
  logic       key_any;
  logic [3:0] key_low;
  always_comb begin
    key_any = |keys_q;
    key_low = '0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        key_low = 4'(k);
      end
    end
  end

  logic vx_key;
  assign vx_key = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];

  // decimal digits by reciprocal multiplication
  logic [13:0] hund_prod, tens_prod;
  logic [1:0]  hund;
  logic [3:0]  tens;
  assign hund_prod = 14'(vx_q) * 14'd41;
  assign hund      = hund_prod[13:12];
  assign tens_prod = 14'(rem_q) * 14'd103;
  assign tens      = tens_prod[13:10];

  logic [ROW_AW-1:0] fb_addr_row_q, fb_addr_row_d;

  // sprite row
  logic [SCREEN_W-1:0] spr_wide, spr_mask, row_old;
  assign spr_wide = {mem_rdata, {(SCREEN_W-8){1'b0}}};
  assign spr_mask = (spr_wide >> vx_q[5:0]) | (spr_wide << (7'(SCREEN_W) - {1'b0, vx_q[5:0]}));
  assign row_old  = fbv_q[fb_addr_row_q] ? fb_rdata : '0;

  logic [8:0] alu_sum;
  assign alu_sum = {1'b0, vx_q} + {1'b0, reg_rdata};

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    i_d      = i_q;
    sp_d     = sp_q;
    dly_d    = dly_q;
    snd_d    = snd_q;
    kwait_d  = kwait_q;
    kdest_d  = kdest_q;
    fbv_d    = fbv_q;
    ins_d    = ins_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    flag_d   = flag_q;
    rem_d    = rem_q;
    ones_d   = ones_q;
    rd_d     = rd_q;
    flt_d    = flt_q;
    fb_addr_row_d = fb_addr_row_q;
    mem_we   = 1'b0;
    mem_addr = pc_q;
    mem_wd   = '0;
    reg_we   = 1'b0;
    reg_addr = xf;
    reg_wd   = '0;
    fb_we    = 1'b0;
    fb_addr  = fb_addr_row_q;
    fb_wd    = '0;
    stk_we   = 1'b0;
    stk_addr = sp_q[StW-1:0];
    stk_wd   = pc_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = cnt_q;
        reg_we   = (cnt_q[MEM_AW-1:4] == '0);
        reg_addr = cnt_q[3:0];
        cnt_d    = cnt_q + 1'b1;
        if (&cnt_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        rd_d  = '0;
        flt_d = FLT_NONE;
        state_d = ST_DONE;
        case (op_q)
          OP_STEP: begin
            if (kwait_q) begin
              if (key_any) begin
                reg_we   = 1'b1;
                reg_addr = kdest_q;
                reg_wd   = {4'h0, key_low};
                kwait_d  = 1'b0;
              end
            end else begin
              mem_addr = pc_q;
              state_d  = ST_FETCH1;
            end
          end
          OP_WRMEM: begin
            mem_we   = 1'b1;
            mem_addr = addr_q;
            mem_wd   = wdata_q;
          end
          OP_TICK: begin
            if (dly_q != '0) dly_d = dly_q - 1'b1;
            if (snd_q != '0) snd_d = snd_q - 1'b1;
          end
          OP_RDMEM: begin
            mem_addr = addr_q;
            state_d  = ST_RDM;
          end
          OP_RDROW: begin
            fb_addr       = addr_q[ROW_AW-1:0];
            fb_addr_row_d = addr_q[ROW_AW-1:0];
            state_d       = ST_RDF;
          end
          default: ;
        endcase
      end
      ST_RDM: begin
        rd_d    = {{(SCREEN_W-8){1'b0}}, mem_rdata};
        state_d = ST_DONE;
      end
      ST_RDF: begin
        rd_d    = row_old;
        state_d = ST_DONE;
      end
      ST_FETCH1: begin
        mem_addr      = pc_q + 1'b1;
        ins_d[15:8]   = mem_rdata;
        state_d       = ST_FETCH2;
      end
      ST_FETCH2: begin
        ins_d[7:0] = mem_rdata;
        pc_d       = pc_q + 12'd2;
        reg_addr   = (cls == CL_JPV0) ? 4'h0 : xf;
        state_d    = ST_RDY;
      end
      ST_RDY: begin
        vx_d     = reg_rdata;
        reg_addr = yf;
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        vy_d    = reg_rdata;
        state_d = ST_DONE;
        case (cls)
          CL_SYS: begin
            if (ins_q == INS_CLS) begin
              fbv_d = '0;
            end else if (ins_q == INS_RET) begin
              if (sp_q == '0) begin
                flt_d = FLT_UNDER;
              end else begin
                sp_d     = sp_q - 1'b1;
                stk_addr = StW'(sp_q - 1'b1);
                state_d  = ST_RET;
              end
            end else begin
              flt_d = FLT_UNKNOWN;
            end
          end
          CL_JP: pc_d = nnn;
          CL_CALL: begin
            if (sp_q == SpW'(StackDepth)) begin
              flt_d = FLT_OVER;
            end else begin
              stk_we = 1'b1;
              sp_d   = sp_q + 1'b1;
              pc_d   = nnn;
            end
          end
          CL_SEB:  if (vx_q == nn) pc_d = pc_q + 12'd2;
          CL_SNEB: if (vx_q != nn) pc_d = pc_q + 12'd2;
          CL_SER:  if (vx_q == reg_rdata) pc_d = pc_q + 12'd2;
          CL_SNER: if (vx_q != reg_rdata) pc_d = pc_q + 12'd2;
          CL_LDB: begin
            reg_we = 1'b1;
            reg_wd = nn;
          end
          CL_ADDB: begin
            reg_we = 1'b1;
            reg_wd = vx_q + nn;
          end
          CL_ALU: begin
            reg_we  = 1'b1;
            state_d = ST_WRF;
            case (nf)
              ALU_MOV: begin reg_wd = reg_rdata;        state_d = ST_DONE; end
              ALU_OR:  begin reg_wd = vx_q | reg_rdata; state_d = ST_DONE; end
              ALU_AND: begin reg_wd = vx_q & reg_rdata; state_d = ST_DONE; end
              ALU_XOR: begin reg_wd = vx_q ^ reg_rdata; state_d = ST_DONE; end
              ALU_ADD: begin
                reg_wd = alu_sum[7:0];
                flag_d = {7'h0, alu_sum[8]};
              end
              ALU_SUB: begin
                reg_wd = vx_q - reg_rdata;
                flag_d = {7'h0, vx_q >= reg_rdata};
              end
              ALU_SHR: begin
                reg_wd = {1'b0, vx_q[7:1]};
                flag_d = {7'h0, vx_q[0]};
              end
              ALU_SBN: begin
                reg_wd = reg_rdata - vx_q;
                flag_d = {7'h0, reg_rdata >= vx_q};
              end
              ALU_SHL: begin
                reg_wd = {vx_q[6:0], 1'b0};
                flag_d = {7'h0, vx_q[7]};
              end
              default: begin
                reg_we  = 1'b0;
                flt_d   = FLT_UNKNOWN;
                state_d = ST_DONE;
              end
            endcase
          end
          CL_LDI:  i_d = nnn;
          CL_JPV0: pc_d = nnn + {4'h0, vx_q};
          CL_RND: begin
            reg_we = 1'b1;
            reg_wd = rnd_q & nn;
          end
          CL_DRW: begin
            cnt_d = '0;
            hit_d = 1'b0;
            if (nf == 4'h0) begin
              flag_d  = '0;
              state_d = ST_WRF;
            end else begin
              state_d = ST_DR0;
            end
          end
          CL_KEY: begin
            if (nn == KEY_SKP) begin
              if (vx_key) pc_d = pc_q + 12'd2;
            end else if (nn == KEY_SKNP) begin
              if (!vx_key) pc_d = pc_q + 12'd2;
            end else begin
              flt_d = FLT_UNKNOWN;
            end
          end
          default: begin
            case (nn)
              F_GDLY: begin
                reg_we = 1'b1;
                reg_wd = dly_q;
              end
              F_WKEY: begin
                kwait_d = 1'b1;
                kdest_d = xf;
              end
              F_SDLY: dly_d = vx_q;
              F_SSND: snd_d = vx_q;
              F_ADDI: i_d = i_q + {4'h0, vx_q};
              F_FONT: i_d = {6'h0, vx_q[3:0], 2'b00} + {8'h0, vx_q[3:0]};
              F_BCD: begin
                mem_we   = 1'b1;
                mem_addr = i_q;
                mem_wd   = {6'h0, hund};
                rem_d    = vx_q - 8'({6'h0, hund} * 8'd100);
                state_d  = ST_BCD1;
              end
              F_STO: begin
                cnt_d   = '0;
                state_d = ST_SRD;
              end
              F_LOAD: begin
                cnt_d   = '0;
                state_d = ST_LRD;
              end
              default: flt_d = FLT_UNKNOWN;
            endcase
          end
        endcase
      end
      ST_RET: begin
        pc_d    = stk_rdata;
        state_d = ST_DONE;
      end
      ST_BCD1: begin
        mem_we   = 1'b1;
        mem_addr = i_q + 12'd1;
        mem_wd   = {4'h0, tens};
        ones_d   = rem_q - 8'({4'h0, tens} * 8'd10);
        state_d  = ST_BCD2;
      end
      ST_BCD2: begin
        mem_we   = 1'b1;
        mem_addr = i_q + 12'd2;
        mem_wd   = ones_q;
        state_d  = ST_DONE;
      end
      ST_SRD: begin
        reg_addr = cnt_q[3:0];
        state_d  = ST_SWR;
      end
      ST_SWR: begin
        mem_we   = 1'b1;
        mem_addr = i_q + cnt_q;
        mem_wd   = reg_rdata;
        cnt_d    = cnt_q + 1'b1;
        state_d  = (cnt_q[3:0] == xf) ? ST_DONE : ST_SRD;
      end
      ST_LRD: begin
        mem_addr = i_q + cnt_q;
        state_d  = ST_LWR;
      end
      ST_LWR: begin
        reg_we   = 1'b1;
        reg_addr = cnt_q[3:0];
        reg_wd   = mem_rdata;
        cnt_d    = cnt_q + 1'b1;
        state_d  = (cnt_q[3:0] == xf) ? ST_DONE : ST_LRD;
      end
      ST_DR0: begin
        mem_addr      = i_q + cnt_q;
        fb_addr       = vy_q[ROW_AW-1:0] + cnt_q[ROW_AW-1:0];
        fb_addr_row_d = fb_addr;
        state_d       = ST_DR1;
      end
      ST_DR1: begin
        fb_we  = 1'b1;
        fb_wd  = row_old ^ spr_mask;
        fbv_d[fb_addr_row_q] = 1'b1;
        hit_d  = hit_q | (|(row_old & spr_mask));
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q[3:0] == nf - 4'h1) begin
          flag_d  = {7'h0, hit_d};
          state_d = ST_WRF;
        end else begin
          state_d = ST_DR0;
        end
      end
      ST_WRF: begin
        reg_we   = 1'b1;
        reg_addr = 4'hF;
        reg_wd   = flag_q;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pc_q    <= PC_START;
      i_q     <= '0;
      sp_q    <= '0;
      dly_q   <= '0;
      snd_q   <= '0;
      kwait_q <= 1'b0;
      kdest_q <= '0;
      fbv_q   <= '0;
      cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      i_q     <= i_d;
      sp_q    <= sp_d;
      dly_q   <= dly_d;
      snd_q   <= snd_d;
      kwait_q <= kwait_d;
      kdest_q <= kdest_d;
      fbv_q   <= fbv_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= op_i;
      addr_q  <= addr_i;
      wdata_q <= wdata_i;
      keys_q  <= key_state_i;
      rnd_q   <= random_byte_i;
    end
    ins_q  <= ins_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    hit_q  <= hit_d;
    flag_q <= flag_d;
    rem_q  <= rem_d;
    ones_q <= ones_d;
    rd_q   <= rd_d;
    flt_q  <= flt_d;
    fb_addr_row_q <= fb_addr_row_d;
    if (out_load) begin
      pc_now_q    <= pc_q;
      read_data_q <= rd_q;
      waiting_q   <= kwait_q;
      sound_on_q  <= (snd_q != '0);
      fault_q     <= flt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pc_now_o    = pc_now_q;
  assign read_data_o = read_data_q;
  assign waiting_o   = waiting_q;
  assign sound_on_o  = sound_on_q;
  assign fault_o     = fault_q;

  // checks
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("stack level beyond depth");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request taken during clearing pass");

  a_fb_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_we |-> (state_q == ST_DR1))
    else $error("frame write outside sprite draw");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> (sp_q != SpW'(StackDepth)))
    else $error("push on a full stack");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking bench for chip8_instruction_executor, with a transaction-level
// predictor in a scoreboard class and random programs written ahead of each step
// depends on c8x_pkg and hdl/chip8_instruction_executor.sv
`timescale 1ns / 1ps

module tb_top;
  import c8x_pkg::*;

  localparam logic [3:0] CL_MISC    = 4'hF;
  localparam logic [2:0] OP_SPARE   = 3'd5;
  localparam int unsigned RAND_REQS = 1950;
  localparam int unsigned CYCLE_CAP = 1000000;

  typedef struct {
    logic [11:0] pc;
    logic [63:0] rd;
    logic        wt;
    logic        snd;
    fault_e      flt;
  } c8_result_t;

  class chip8_scoreboard;
    bit [7:0]   mem [MEM_BYTES];
    bit [7:0]   v [16];
    bit [63:0]  rows [SCREEN_H];
    bit [11:0]  pc, idx;
    bit [11:0]  stk [STACK_DEPTH];
    int unsigned lvl;
    bit [7:0]   dly, snd;
    bit         kw;
    bit [3:0]   kdst;
    c8_result_t result_q[$];
    int unsigned errors;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (v[i]) v[i] = '0;
      foreach (rows[i]) rows[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      pc = PC_START; idx = '0; lvl = 0; dly = '0; snd = '0; kw = 1'b0; kdst = '0;
      errors = 0;
    endfunction

    function fault_e alu_ins(bit [3:0] x, bit [3:0] y, bit [3:0] n);
      bit [7:0] a, b;
      bit [8:0] sum;
      a = v[x]; b = v[y];
      case (n)
        ALU_MOV: v[x] = b;
        ALU_OR:  v[x] = a | b;
        ALU_AND: v[x] = a & b;
        ALU_XOR: v[x] = a ^ b;
        ALU_ADD: begin sum = a + b; v[x] = sum[7:0]; v[15] = {7'd0, sum[8]}; end
        ALU_SUB: begin v[x] = a - b; v[15] = {7'd0, a >= b}; end
        ALU_SHR: begin v[x] = a >> 1; v[15] = {7'd0, a[0]}; end
        ALU_SBN: begin v[x] = b - a; v[15] = {7'd0, b >= a}; end
        ALU_SHL: begin v[x] = a << 1; v[15] = {7'd0, a[7]}; end
        default: return FLT_UNKNOWN;
      endcase
      return FLT_NONE;
    endfunction

    function void draw(bit [3:0] x, bit [3:0] y, bit [3:0] n);
      int vx, vy, py, px;
      bit hit;
      bit [7:0] bits;
      bit [63:0] m;
      vx = v[x]; vy = v[y]; hit = 1'b0;
      for (int r = 0; r < n; r++) begin
        bits = mem[idx + 12'(r)];
        py = (vy + r) % SCREEN_H;
        for (int c = 0; c < 8; c++) begin
          if (bits[7-c]) begin
            px = (vx + c) % SCREEN_W;
            m = 64'h1 << (63 - px);
            if ((rows[py] & m) != 0) hit = 1'b1;
            rows[py] ^= m;
          end
        end
      end
      v[15] = {7'd0, hit};
    endfunction

    function fault_e exec_ins(bit [15:0] keys, bit [7:0] rnd);
      bit [15:0] ins;
      bit [3:0] x, y;
      bit [7:0] nn;
      bit [11:0] nnn;
      bit held;
      ins = {mem[pc], mem[pc + 12'd1]};
      x = ins[11:8]; y = ins[7:4]; nn = ins[7:0]; nnn = ins[11:0];
      held = (v[x] <= 8'd15) && keys[v[x][3:0]];
      pc = pc + 12'd2;
      case (ins[15:12])
        CL_SYS: begin
          if (ins == INS_CLS) begin
            foreach (rows[i]) rows[i] = '0;
          end else if (ins == INS_RET) begin
            if (lvl == 0) return FLT_UNDER;
            lvl--;
            pc = stk[lvl];
          end else return FLT_UNKNOWN;
        end
        CL_JP: pc = nnn;
        CL_CALL: begin
          if (lvl >= STACK_DEPTH) return FLT_OVER;
          stk[lvl] = pc;
          lvl++;
          pc = nnn;
        end
        CL_SEB:  if (v[x] == nn) pc = pc + 12'd2;
        CL_SNEB: if (v[x] != nn) pc = pc + 12'd2;
        CL_SER:  if (v[x] == v[y]) pc = pc + 12'd2;
        CL_LDB:  v[x] = nn;
        CL_ADDB: v[x] = v[x] + nn;
        CL_ALU:  return alu_ins(x, y, ins[3:0]);
        CL_SNER: if (v[x] != v[y]) pc = pc + 12'd2;
        CL_LDI:  idx = nnn;
        CL_JPV0: pc = nnn + 12'(v[0]);
        CL_RND:  v[x] = rnd & nn;
        CL_DRW:  draw(x, y, ins[3:0]);
        CL_KEY: begin
          if (nn == KEY_SKP) begin
            if (held) pc = pc + 12'd2;
          end else if (nn == KEY_SKNP) begin
            if (!held) pc = pc + 12'd2;
          end else return FLT_UNKNOWN;
        end
        default: begin
          case (nn)
            F_GDLY: v[x] = dly;
            F_WKEY: begin kw = 1'b1; kdst = x; end
            F_SDLY: dly = v[x];
            F_SSND: snd = v[x];
            F_ADDI: idx = idx + 12'(v[x]);
            F_FONT: idx = 12'(v[x][3:0]) * 12'd5;
            F_BCD: begin
              mem[idx]         = v[x] / 100;
              mem[idx + 12'd1] = (v[x] / 10) % 10;
              mem[idx + 12'd2] = v[x] % 10;
            end
            F_STO:  for (int i = 0; i <= x; i++) mem[idx + 12'(i)] = v[i];
            F_LOAD: for (int i = 0; i <= x; i++) v[i] = mem[idx + 12'(i)];
            default: return FLT_UNKNOWN;
          endcase
        end
      endcase
      return FLT_NONE;
    endfunction

    function void note_request(logic [2:0] op, logic [11:0] addr, logic [7:0] wdata,
                               logic [15:0] keys, logic [7:0] rnd);
      c8_result_t e;
      bit found;
      e.rd = '0; e.flt = FLT_NONE; found = 1'b0;
      case (op)
        OP_STEP: begin
          if (kw) begin
            for (int k = 0; k < 16; k++) begin
              if (keys[k] && !found) begin
                v[kdst] = 8'(k);
                kw = 1'b0;
                found = 1'b1;
              end
            end
          end else e.flt = exec_ins(keys, rnd);
        end
        OP_WRMEM: mem[addr] = wdata;
        OP_TICK: begin
          if (dly != 0) dly--;
          if (snd != 0) snd--;
        end
        OP_RDMEM: e.rd = {56'd0, mem[addr]};
        OP_RDROW: e.rd = rows[addr[4:0]];
        default: ;
      endcase
      e.pc = pc; e.wt = kw; e.snd = (snd != 0);
      result_q.push_back(e);
    endfunction

    function void check_result(c8_result_t got);
      c8_result_t e;
      if (result_q.size() == 0) begin
        $display("%0t: result with nothing expected, pc %h", $time, got.pc);
        errors++;
        return;
      end
      e = result_q.pop_front();
      if (got.pc !== e.pc) begin
        $display("%0t: pc_now expected %h actual %h", $time, e.pc, got.pc); errors++;
      end
      if (got.rd !== e.rd) begin
        $display("%0t: read_data expected %h actual %h", $time, e.rd, got.rd); errors++;
      end
      if (got.wt !== e.wt) begin
        $display("%0t: waiting expected %b actual %b", $time, e.wt, got.wt); errors++;
      end
      if (got.snd !== e.snd) begin
        $display("%0t: sound_on expected %b actual %b", $time, e.snd, got.snd); errors++;
      end
      if (got.flt !== e.flt) begin
        $display("%0t: fault expected %0d actual %0d", $time, e.flt, got.flt); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_r = '0;
  logic [11:0] addr_r = '0;
  logic [7:0]  wdata_r = '0;
  logic [15:0] keys_r = '0;
  logic [7:0]  rnd_r = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [11:0] pc_now_o;
  logic [63:0] read_data_o;
  logic        waiting_o, sound_on_o;
  logic [1:0]  fault_o;

  chip8_scoreboard sb;
  int unsigned send_idle = 7, recv_idle = 48;
  int unsigned requests_sent = 0;
  int unsigned cycles = 0;
  bit          drained = 1'b0;

  chip8_instruction_executor dut (
    .clk_i, .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o,
    .op_i(op_r), .addr_i(addr_r), .wdata_i(wdata_r),
    .key_state_i(keys_r), .random_byte_i(rnd_r),
    .out_valid_o, .out_ready_i(out_ready),
    .pc_now_o, .read_data_o, .waiting_o, .sound_on_o, .fault_o
  );

  initial forever #4 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    c8_result_t got;
    if (out_valid_o && out_ready) begin
      got.pc = pc_now_o; got.rd = read_data_o; got.wt = waiting_o;
      got.snd = sound_on_o; got.flt = fault_e'(fault_o);
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("chip8_instruction_executor test failed");
      $finish;
    end
  end

  task automatic send_req(logic [2:0] op, logic [11:0] addr, logic [7:0] wdata,
                          logic [15:0] keys, logic [7:0] rnd);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1; op_r <= op; addr_r <= addr; wdata_r <= wdata;
    keys_r <= keys; rnd_r <= rnd;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, addr, wdata, keys, rnd);
    requests_sent++;
  endtask

  function automatic logic [15:0] rand_keys();
    case ($urandom_range(3))
      0: return '0;
      1: return 16'h1 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // place the word at the current pc, then step it
  task automatic exec_word(logic [15:0] ins, logic [15:0] keys);
    logic [11:0] at;
    at = sb.pc;
    send_req(OP_WRMEM, at, ins[15:8], 16'($urandom), 8'($urandom));
    send_req(OP_WRMEM, at + 12'd1, ins[7:0], 16'($urandom), 8'($urandom));
    send_req(OP_STEP, 12'($urandom), 8'($urandom), keys, 8'($urandom));
  endtask

  function automatic logic [15:0] rand_word();
    logic [3:0] cls, x, y;
    logic [7:0] nn;
    cls = 4'($urandom); x = 4'($urandom); y = 4'($urandom); nn = 8'($urandom);
    case (cls)
      CL_SYS: begin
        case ($urandom_range(3))
          0: return INS_CLS;
          1, 2: return INS_RET;
          default: return {CL_SYS, x, nn};
        endcase
      end
      CL_KEY: begin
        if ($urandom_range(9) == 0) return {CL_KEY, x, nn};
        return {CL_KEY, x, $urandom_range(1) ? KEY_SKP : KEY_SKNP};
      end
      CL_MISC: begin
        case ($urandom_range(10))
          0: return {CL_MISC, x, F_GDLY};
          1: return {CL_MISC, x, F_WKEY};
          2: return {CL_MISC, x, F_SDLY};
          3: return {CL_MISC, x, F_SSND};
          4: return {CL_MISC, x, F_ADDI};
          5: return {CL_MISC, x, F_FONT};
          6: return {CL_MISC, x, F_BCD};
          7: return {CL_MISC, x, F_STO};
          8: return {CL_MISC, x, F_LOAD};
          default: return {CL_MISC, x, nn};
        endcase
      end
      default: return {cls, x, y, nn[3:0]};
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    // directed: reset contents, spare ops, extremes and the special cases
    send_req(OP_RDMEM, 12'hFFF, 8'h00, 16'hFFFF, 8'hFF);
    send_req(OP_RDROW, 12'hFFF, 8'hFF, 16'h0000, 8'h00);
    for (int k = 0; k < 3; k++) send_req(OP_SPARE + 3'(k), 12'hABC, 8'h5A, 16'h1234, 8'h77);
    send_req(OP_WRMEM, 12'hFFF, 8'hFF, 16'h0, 8'h0);
    send_req(OP_RDMEM, 12'hFFF, 8'h00, 16'h0, 8'h0);
    send_req(OP_TICK, 12'h000, 8'h00, 16'h0, 8'h0);
    exec_word(INS_RET, 16'h0);                          // return on empty stack
    exec_word(16'h0123, 16'h0);                         // unknown system word
    exec_word({CL_LDB, 4'h0, 8'hFF}, 16'h0);
    exec_word({CL_KEY, 4'h0, KEY_SKP}, 16'hFFFF);       // key number out of range
    exec_word({CL_MISC, 4'h0, F_WKEY}, 16'h0);
    send_req(OP_STEP, 12'h0, 8'h0, 16'h0000, 8'h0);     // still waiting
    send_req(OP_STEP, 12'h0, 8'h0, 16'h8010, 8'h0);     // lowest key wins
    exec_word({CL_DRW, 4'h0, 4'h1, 4'hF}, 16'h0);
    send_req(OP_RDROW, 12'h000, 8'h00, 16'h0, 8'h0);

    while (requests_sent < RAND_REQS) begin
      if (requests_sent > (2 * RAND_REQS) / 3) begin
        send_idle = 0; recv_idle = 0;
      end else if (requests_sent > RAND_REQS / 3) begin
        send_idle = 48; recv_idle = 7;
      end
      if (!drained && requests_sent > RAND_REQS / 2) begin
        drained = 1'b1;
        @(negedge clk_i);
        in_valid <= 1'b0;
        while (sb.result_q.size() != 0) @(posedge clk_i);
      end
      case ($urandom_range(99)) inside
        [0:1]: begin
          // deep call chain to reach the full stack, then unwind past empty
          repeat (STACK_DEPTH + 2) exec_word({CL_CALL, 12'($urandom)}, rand_keys());
          repeat (STACK_DEPTH + 2) exec_word(INS_RET, rand_keys());
        end
        [2:71]: exec_word(rand_word(), rand_keys());
        [72:77]: send_req(OP_STEP, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
        [78:83]: send_req(OP_WRMEM, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
        [84:89]: send_req(OP_TICK, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
        [90:94]: send_req(OP_RDMEM, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
        default: send_req(OP_RDROW, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
      endcase
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("chip8_instruction_executor test passed");
    end else begin
      $display("chip8_instruction_executor test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/c8x_pkg.sv
hdl/chip8_instruction_executor.sv
verif/tb_top.sv
